// File: rtl/core/sdf_pkg.sv
// Shared widths, register indices and latency for the spring-damper force unit.
// No dependencies; imported by the top level and the port checker.
package sdf_pkg;

  localparam int D_W     = 33;   // anchor difference, magnitude below 2^32
  localparam int DD_W    = 66;   // squared separation, Q.32
  localparam int G_NUM_W = 114;  // damping numerator, Q.32 scaled
  localparam int G_Q_W   = 96;   // damping quotient, clamped above this
  localparam int SQ_X_W  = 98;   // squared length radicand, Q.64
  localparam int LQ_W    = SQ_X_W / 2;
  localparam int RQ_W    = 47;
  localparam int T_NUM_W = 98;
  localparam int T_Q_W   = 78;
  localparam int E_W     = 94;
  localparam int SMAG_W  = 97;
  localparam int SC_W    = 64;
  localparam int M_W     = 66;

  // Register stages from start to done: front end, damping divider,
  // square root, elastic prep, elastic divider, back end.
  localparam int LATENCY = 7 + (G_Q_W + 1) + (LQ_W + 1) + 3 + (T_Q_W + 1) + 6;

  localparam logic signed [31:0] FORCE_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] FORCE_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    REG_STRETCH  = 2'd0,
    REG_COMPRESS = 2'd1,
    REG_DAMPING  = 2'd2,
    REG_REST     = 2'd3
  } reg_idx_t;

endpackage

// File: rtl/core/sdf_div.sv
// Pipelined restoring divider, one quotient bit per stage, with sideband word.
// Stand-alone; the quotient saturates to all ones when it would not fit.
module sdf_div #(
  parameter int NUM_W  = 98,
  parameter int DEN_W  = 49,
  parameter int Q_W    = 78,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  in_num,
  input  logic [DEN_W-1:0]  in_den,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [Q_W-1:0]    out_quot,
  output logic [SIDE_W-1:0] out_side
);

  localparam int CW = (NUM_W > DEN_W) ? NUM_W : DEN_W;

  logic              vld  [0:Q_W];
  logic [DEN_W-1:0]  rem  [0:Q_W];
  logic [Q_W-1:0]    quo  [0:Q_W];
  logic [Q_W-1:0]    nlo  [0:Q_W];
  logic [DEN_W-1:0]  den  [0:Q_W];
  logic              ovf  [0:Q_W];
  logic [SIDE_W-1:0] side [0:Q_W];

  // load: upper numerator bits form the first partial remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    rem[0]  <= DEN_W'(in_num >> Q_W);
    nlo[0]  <= in_num[Q_W-1:0];
    quo[0]  <= '0;
    den[0]  <= in_den;
    ovf[0]  <= (CW'(in_num >> Q_W) >= CW'(in_den));
    side[0] <= in_side;
  end

  genvar k;
  for (k = 1; k <= Q_W; k++) begin : g_step
    logic [DEN_W:0] cand;
    logic [DEN_W:0] sub;
    logic           ge;
    assign cand = {rem[k-1], nlo[k-1][Q_W-1]};
    assign ge   = (cand >= {1'b0, den[k-1]});
    assign sub  = cand - {1'b0, den[k-1]};
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
      rem[k]  <= ge ? sub[DEN_W-1:0] : cand[DEN_W-1:0];
      quo[k]  <= {quo[k-1][Q_W-2:0], ge};
      nlo[k]  <= nlo[k-1] << 1;
      den[k]  <= den[k-1];
      ovf[k]  <= ovf[k-1];
      side[k] <= side[k-1];
    end
  end

  assign out_valid = vld[Q_W];
  assign out_quot  = ovf[Q_W] ? '1 : quo[Q_W];
  assign out_side  = side[Q_W];

endmodule

// File: rtl/core/sdf_sqrt.sv
// Pipelined integer square root, one root bit per stage, with sideband word.
// Stand-alone; also reports whether the radicand was a perfect square.
module sdf_sqrt #(
  parameter int X_W    = 98,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [X_W-1:0]    in_x,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [X_W/2-1:0]  out_root,
  output logic              out_rem_nz,
  output logic [SIDE_W-1:0] out_side
);

  localparam int R_W = X_W / 2;

  logic              vld  [0:R_W];
  logic [R_W+1:0]    rem  [0:R_W];
  logic [R_W-1:0]    root [0:R_W];
  logic [X_W-1:0]    xs   [0:R_W];
  logic [SIDE_W-1:0] side [0:R_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld[0] <= 1'b0;
    end else begin
      vld[0] <= in_valid;
    end
    rem[0]  <= '0;
    root[0] <= '0;
    xs[0]   <= in_x;
    side[0] <= in_side;
  end

  genvar k;
  for (k = 1; k <= R_W; k++) begin : g_step
    logic [R_W+1:0] cand;
    logic [R_W+1:0] trial;
    logic           ge;
    // bring down the next bit pair, try root*4+1
    assign cand  = {rem[k-1][R_W-1:0], xs[k-1][X_W-1 -: 2]};
    assign trial = {root[k-1], 2'b01};
    assign ge    = (cand >= trial);
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= vld[k-1];
      end
      rem[k]  <= ge ? (cand - trial) : cand;
      root[k] <= {root[k-1][R_W-2:0], ge};
      xs[k]   <= xs[k-1] << 2;
      side[k] <= side[k-1];
    end
  end

  assign out_valid  = vld[R_W];
  assign out_root   = root[R_W];
  assign out_rem_nz = |rem[R_W];
  assign out_side   = side[R_W];

endmodule

// File: rtl/core/spring_damper_force.sv
// Spring-damper force unit: done follows an accepted start after LATENCY (sdf_pkg).
// Throughput is one word per cycle while busy is low; busy is set during reset
// and clears once reset is released, then stays low. Depth is set by the two
// bit-per-stage dividers and the bit-per-stage root.
// Synchronous active-high reset empties the pipeline and loads register defaults.
// Depends on sdf_pkg, sdf_div and sdf_sqrt.
module spring_damper_force
  import sdf_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] anchor1_x,
  input  logic signed [31:0] anchor1_y,
  input  logic signed [31:0] anchor1_z,
  input  logic signed [31:0] anchor2_x,
  input  logic signed [31:0] anchor2_y,
  input  logic signed [31:0] anchor2_z,
  input  logic signed [31:0] vel1_x,
  input  logic signed [31:0] vel1_y,
  input  logic signed [31:0] vel1_z,
  input  logic signed [31:0] vel2_x,
  input  logic signed [31:0] vel2_y,
  input  logic signed [31:0] vel2_z,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [31:0]        cfg_wdata,
  output logic               done,
  output logic signed [31:0] force_x,
  output logic signed [31:0] force_y,
  output logic signed [31:0] force_z,
  output logic               applied,
  output logic               saturated
);

  // Per-axis data that rides along the whole pipeline.
  typedef struct packed {
    logic [2:0][D_W-1:0] ad;     // |anchor2 - anchor1|
    logic [2:0]          dn;     // difference negative
    logic                gneg;   // relative velocity closing the gap
    logic                dzero;  // anchors coincide
  } axis_t;

  typedef struct packed {
    axis_t           ax;
    logic [DD_W-1:0] dd;
  } gside_t;

  typedef struct packed {
    axis_t            ax;
    logic [G_Q_W-1:0] g;
  } qside_t;

  typedef struct packed {
    axis_t            ax;
    logic [G_Q_W-1:0] g;
    logic             stretched;
    logic [31:0]      gain;
  } tside_t;

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [31:0] stretch_gain;
  logic [31:0] compress_gain;
  logic [31:0] damping_gain;
  logic [30:0] rest_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      stretch_gain  <= 32'd6553600;
      compress_gain <= 32'd6553600;
      damping_gain  <= 32'd0;
      rest_length   <= 31'd0;
      busy          <= 1'b1;
    end else begin
      busy <= 1'b0;
      if (cfg_we) begin
        case (reg_idx_t'(cfg_addr))
          REG_STRETCH:  stretch_gain  <= cfg_wdata;
          REG_COMPRESS: compress_gain <= cfg_wdata;
          REG_DAMPING:  damping_gain  <= cfg_wdata;
          REG_REST:     rest_length   <= cfg_wdata[30:0];
          default:      ;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------
  // Front end: differences, magnitudes, products, dot-product sums
  // ---------------------------------------------------------------
  logic signed [31:0] a1 [3];
  logic signed [31:0] a2 [3];
  logic signed [31:0] v1 [3];
  logic signed [31:0] v2 [3];

  assign a1[0] = anchor1_x;  assign a1[1] = anchor1_y;  assign a1[2] = anchor1_z;
  assign a2[0] = anchor2_x;  assign a2[1] = anchor2_y;  assign a2[2] = anchor2_z;
  assign v1[0] = vel1_x;     assign v1[1] = vel1_y;     assign v1[2] = vel1_z;
  assign v2[0] = vel2_x;     assign v2[1] = vel2_y;     assign v2[2] = vel2_z;

  logic                    s1_vld;
  logic signed [D_W-1:0]   s1_d  [3];
  logic signed [D_W-1:0]   s1_dv [3];

  logic                    s2_vld;
  logic [2:0][D_W-1:0]     s2_ad;
  logic [2:0][D_W-1:0]     s2_adv;
  logic [2:0]              s2_dn;
  logic [2:0]              s2_mix;

  logic                    s3_vld;
  logic [2:0][D_W-1:0]     s3_ad;
  logic [2:0]              s3_dn;
  logic [2:0]              s3_mix;
  logic [DD_W-1:0]         s3_sq [3];
  logic [DD_W-1:0]         s3_pr [3];

  logic                    s4_vld;
  logic [2:0][D_W-1:0]     s4_ad;
  logic [2:0]              s4_dn;
  logic [DD_W-1:0]         s4_dd;
  logic [DD_W-1:0]         s4_dpos;
  logic [DD_W-1:0]         s4_dneg;
  logic [DD_W-1:0]         s4_dd_next;
  logic [DD_W-1:0]         s4_dpos_next;
  logic [DD_W-1:0]         s4_dneg_next;

  logic                    s5_vld;
  axis_t                   s5_ax;
  logic [DD_W-1:0]         s5_dd;
  logic [DD_W-1:0]         s5_dmag;

  logic                    s6_vld;
  axis_t                   s6_ax;
  logic [DD_W-1:0]         s6_dd;
  logic [64:0]             s6_plo;
  logic [64:0]             s6_phi;

  logic                    s7_vld;
  axis_t                   s7_ax;
  logic [DD_W-1:0]         s7_dd;
  logic [G_NUM_W-1:0]      s7_num;
  logic [97:0]             s7_prod;

  // sum the squares and split the dot product by sign of each term
  always_comb begin
    s4_dd_next   = '0;
    s4_dpos_next = '0;
    s4_dneg_next = '0;
    for (int i = 0; i < 3; i++) begin
      s4_dd_next = s4_dd_next + s3_sq[i];
      if (s3_mix[i]) begin
        s4_dneg_next = s4_dneg_next + s3_pr[i];
      end else begin
        s4_dpos_next = s4_dpos_next + s3_pr[i];
      end
    end
  end

  assign s7_prod = {s6_phi, 33'b0} + 98'(s6_plo);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
      s2_vld <= 1'b0;
      s3_vld <= 1'b0;
      s4_vld <= 1'b0;
      s5_vld <= 1'b0;
      s6_vld <= 1'b0;
      s7_vld <= 1'b0;
    end else begin
      s1_vld <= start & ~busy;
      s2_vld <= s1_vld;
      s3_vld <= s2_vld;
      s4_vld <= s3_vld;
      s5_vld <= s4_vld;
      s6_vld <= s5_vld;
      s7_vld <= s6_vld;
    end
    for (int i = 0; i < 3; i++) begin
      s1_d[i]   <= $signed({a2[i][31], a2[i]}) - $signed({a1[i][31], a1[i]});
      s1_dv[i]  <= $signed({v2[i][31], v2[i]}) - $signed({v1[i][31], v1[i]});
      s2_ad[i]  <= s1_d[i][D_W-1]  ? D_W'(-s1_d[i])  : D_W'(s1_d[i]);
      s2_adv[i] <= s1_dv[i][D_W-1] ? D_W'(-s1_dv[i]) : D_W'(s1_dv[i]);
      s2_dn[i]  <= s1_d[i][D_W-1];
      s2_mix[i] <= s1_d[i][D_W-1] ^ s1_dv[i][D_W-1];
      s3_sq[i]  <= s2_ad[i] * s2_ad[i];
      s3_pr[i]  <= s2_ad[i] * s2_adv[i];
    end
    s3_ad  <= s2_ad;
    s3_dn  <= s2_dn;
    s3_mix <= s2_mix;

    s4_ad   <= s3_ad;
    s4_dn   <= s3_dn;
    s4_dd   <= s4_dd_next;
    s4_dpos <= s4_dpos_next;
    s4_dneg <= s4_dneg_next;

    // magnitude of the relative speed along the axis, sign held apart
    s5_ax.ad    <= s4_ad;
    s5_ax.dn    <= s4_dn;
    s5_ax.gneg  <= (s4_dpos < s4_dneg);
    s5_ax.dzero <= (s4_dd == '0);
    s5_dd       <= s4_dd;
    s5_dmag     <= (s4_dpos >= s4_dneg) ? (s4_dpos - s4_dneg) : (s4_dneg - s4_dpos);

    // damping product in two halves, summed next cycle
    s6_ax  <= s5_ax;
    s6_dd  <= s5_dd;
    s6_plo <= s5_dmag[32:0] * damping_gain;
    s6_phi <= s5_dmag[65:33] * damping_gain;

    s7_ax  <= s6_ax;
    s7_dd  <= s6_dd;
    s7_num <= {s7_prod, 16'b0};
  end

  // ---------------------------------------------------------------
  // Damping scalar: g = damping * |dot| * 2^16 / dd
  // ---------------------------------------------------------------
  gside_t                 gd_in;
  logic                   gd_vld;
  logic [G_Q_W-1:0]       gd_q;
  logic [$bits(gside_t)-1:0] gd_side;
  gside_t                 gd_s;

  assign gd_in.ax = s7_ax;
  assign gd_in.dd = s7_dd;
  assign gd_s     = gd_side;

  sdf_div #(
    .NUM_W  (G_NUM_W),
    .DEN_W  (DD_W),
    .Q_W    (G_Q_W),
    .SIDE_W ($bits(gside_t))
  ) u_gdiv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s7_vld),
    .in_num    (s7_num),
    .in_den    (s7_dd),
    .in_side   (gd_in),
    .out_valid (gd_vld),
    .out_quot  (gd_q),
    .out_side  (gd_side)
  );

  // ---------------------------------------------------------------
  // Length: Lq = floor(sqrt(dd * 2^32)), plus exactness for the compare
  // ---------------------------------------------------------------
  qside_t                    sq_in;
  logic                      sq_vld;
  logic [LQ_W-1:0]           sq_root;
  logic                      sq_rnz;
  logic [$bits(qside_t)-1:0] sq_side;
  qside_t                    sq_s;

  // coincident anchors give no damping
  assign sq_in.ax = gd_s.ax;
  assign sq_in.g  = gd_s.ax.dzero ? '0 : gd_q;
  assign sq_s     = sq_side;

  sdf_sqrt #(
    .X_W    (SQ_X_W),
    .SIDE_W ($bits(qside_t))
  ) u_sqrt (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (gd_vld),
    .in_x       ({gd_s.dd, 32'b0}),
    .in_side    (sq_in),
    .out_valid  (sq_vld),
    .out_root   (sq_root),
    .out_rem_nz (sq_rnz),
    .out_side   (sq_side)
  );

  // ---------------------------------------------------------------
  // Elastic prep: branch, |Lq - R|, and its square
  // ---------------------------------------------------------------
  logic [LQ_W-1:0]  rq;
  logic             p1_str_next;

  logic             p1_vld;
  logic [LQ_W-1:0]  p1_lq;
  logic [LQ_W-1:0]  p1_diff;
  tside_t           p1_side;

  logic             p2_vld;
  logic [LQ_W-1:0]  p2_lq;
  tside_t           p2_side;
  logic [49:0]      p2_ll;
  logic [48:0]      p2_lh;
  logic [47:0]      p2_hh;

  logic             p3_vld;
  logic [LQ_W-1:0]  p3_lq;
  tside_t           p3_side;
  logic [T_NUM_W-1:0] p3_sq;

  assign rq = LQ_W'({rest_length, 16'b0});

  // stretched exactly when dd * 2^32 > R^2: root above R, or equal with a remainder
  assign p1_str_next = (sq_root > rq) || ((sq_root == rq) && sq_rnz);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_vld <= 1'b0;
      p2_vld <= 1'b0;
      p3_vld <= 1'b0;
    end else begin
      p1_vld <= sq_vld;
      p2_vld <= p1_vld;
      p3_vld <= p2_vld;
    end
    p1_lq             <= sq_root;
    p1_diff           <= (sq_root > rq) ? (sq_root - rq) : (rq - sq_root);
    p1_side.ax        <= sq_s.ax;
    p1_side.g         <= sq_s.g;
    p1_side.stretched <= p1_str_next;
    p1_side.gain      <= p1_str_next ? stretch_gain : compress_gain;

    // square in halves: 25-bit low part, 24-bit high part
    p2_lq   <= p1_lq;
    p2_side <= p1_side;
    p2_ll   <= p1_diff[24:0] * p1_diff[24:0];
    p2_lh   <= p1_diff[24:0] * p1_diff[48:25];
    p2_hh   <= p1_diff[48:25] * p1_diff[48:25];

    p3_lq   <= p2_lq;
    p3_side <= p2_side;
    p3_sq   <= T_NUM_W'({p2_hh, 50'b0}) + T_NUM_W'({p2_lh, 26'b0}) + T_NUM_W'(p2_ll);
  end

  // ---------------------------------------------------------------
  // t = diff^2 / Lq
  // ---------------------------------------------------------------
  logic                      td_vld;
  logic [T_Q_W-1:0]          td_q;
  logic [$bits(tside_t)-1:0] td_side;
  tside_t                    td_s;

  assign td_s = td_side;

  sdf_div #(
    .NUM_W  (T_NUM_W),
    .DEN_W  (LQ_W),
    .Q_W    (T_Q_W),
    .SIDE_W ($bits(tside_t))
  ) u_tdiv (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (p3_vld),
    .in_num    (p3_sq),
    .in_den    (p3_lq),
    .in_side   (p3_side),
    .out_valid (td_vld),
    .out_quot  (td_q),
    .out_side  (td_side)
  );

  // ---------------------------------------------------------------
  // Back end: e = t*gain/2^16, combine with damping, scale each axis
  // ---------------------------------------------------------------
  logic [T_Q_W-1:0]   e1_t;

  logic               e1_vld;
  tside_t             e1_side;
  logic [57:0]        e1_p [3];

  logic               e2_vld;
  tside_t             e2_side;
  logic [E_W-1:0]     e2_e;
  logic [109:0]       e2_sum;

  logic [SMAG_W-1:0]  c_e;
  logic [SMAG_W-1:0]  c_g;
  logic [SMAG_W-1:0]  c_smag;
  logic               c_neg0;

  logic               c_vld;
  logic [2:0][D_W-1:0] c_ad;
  logic [2:0]         c_dn;
  logic               c_app;
  logic [SC_W-1:0]    c_sc;
  logic               c_sneg;

  logic               m1_vld;
  logic [2:0]         m1_dn;
  logic               m1_app;
  logic               m1_sneg;
  logic [64:0]        m1_lo [3];
  logic [64:0]        m1_hi [3];

  logic               m2_vld;
  logic [2:0]         m2_dn;
  logic               m2_app;
  logic               m2_sneg;
  logic [M_W-1:0]     m2_m [3];

  logic signed [31:0] f_next [3];
  logic [2:0]         f_sat;

  assign e1_t   = td_s.ax.dzero ? '0 : td_q;
  assign e2_sum = 110'(e1_p[0]) + 110'({e1_p[1], 26'b0}) + 110'({e1_p[2], 52'b0});

  // signed combination of elastic and damping parts
  always_comb begin
    c_e = SMAG_W'(e2_e);
    c_g = SMAG_W'(e2_side.g);
    if (e2_side.ax.gneg) begin
      c_smag = c_e + c_g;
      c_neg0 = 1'b0;
    end else if (c_e >= c_g) begin
      c_smag = c_e - c_g;
      c_neg0 = 1'b0;
    end else begin
      c_smag = c_g - c_e;
      c_neg0 = 1'b1;
    end
  end

  // clamp each axis into the output range
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f_next[i] = '0;
      f_sat[i]  = 1'b0;
      if (m2_app) begin
        if ((m2_dn[i] != m2_sneg) && (m2_m[i] != '0)) begin
          if (m2_m[i] > M_W'(33'h0_8000_0000)) begin
            f_next[i] = FORCE_MIN;
            f_sat[i]  = 1'b1;
          end else begin
            f_next[i] = $signed(~m2_m[i][31:0] + 32'd1);
          end
        end else begin
          if (m2_m[i] > M_W'(33'h0_7FFF_FFFF)) begin
            f_next[i] = FORCE_MAX;
            f_sat[i]  = 1'b1;
          end else begin
            f_next[i] = $signed(m2_m[i][31:0]);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e1_vld <= 1'b0;
      e2_vld <= 1'b0;
      c_vld  <= 1'b0;
      m1_vld <= 1'b0;
      m2_vld <= 1'b0;
      done   <= 1'b0;
    end else begin
      e1_vld <= td_vld;
      e2_vld <= e1_vld;
      c_vld  <= e2_vld;
      m1_vld <= c_vld;
      m2_vld <= m1_vld;
      done   <= m2_vld;
    end

    // elastic product in three 26-bit slices of t
    e1_side <= td_s;
    for (int j = 0; j < 3; j++) begin
      e1_p[j] <= e1_t[26*j +: 26] * td_s.gain;
    end

    e2_side <= e1_side;
    e2_e    <= e2_sum[109:16];

    // flip the sign on the compressed branch, clamp to 64 bits
    c_ad   <= e2_side.ax.ad;
    c_dn   <= e2_side.ax.dn;
    c_app  <= (e2_side.gain != '0);
    c_sneg <= e2_side.stretched ? c_neg0 : ~c_neg0;
    c_sc   <= (|c_smag[SMAG_W-1:SC_W]) ? '1 : c_smag[SC_W-1:0];

    m1_dn   <= c_dn;
    m1_app  <= c_app;
    m1_sneg <= c_sneg;
    for (int i = 0; i < 3; i++) begin
      m1_lo[i] <= c_ad[i] * c_sc[31:0];
      m1_hi[i] <= c_ad[i] * c_sc[63:32];
    end

    m2_dn   <= m1_dn;
    m2_app  <= m1_app;
    m2_sneg <= m1_sneg;
    for (int i = 0; i < 3; i++) begin
      m2_m[i] <= M_W'(m1_hi[i]) + M_W'(m1_lo[i][64:32]);
    end

    force_x   <= f_next[0];
    force_y   <= f_next[1];
    force_z   <= f_next[2];
    applied   <= m2_app;
    saturated <= |f_sat;
  end

endmodule

// File: rtl/core/sdf_chk.sv
// Port-level checker for spring_damper_force, attached by the bind below.
// Depends on sdf_pkg for the pipeline latency and force limits.
module sdf_chk
  import sdf_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               start,
  input logic               busy,
  input logic               done,
  input logic signed [31:0] force_x,
  input logic signed [31:0] force_y,
  input logic signed [31:0] force_z,
  input logic               applied,
  input logic               saturated
);

  a_lat: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result word without a matching start");

  a_off: assert property (@(posedge clk) disable iff (rst)
    (done && !applied) |-> (force_x == 0 && force_y == 0 && force_z == 0 && !saturated))
    else $error("force present with zero gain");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    (done && saturated) |-> (force_x == FORCE_MAX || force_x == FORCE_MIN ||
                             force_y == FORCE_MAX || force_y == FORCE_MIN ||
                             force_z == FORCE_MAX || force_z == FORCE_MIN))
    else $error("saturation flagged with no clamped component");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    !rst |=> !busy)
    else $error("busy raised outside reset");

endmodule

bind spring_damper_force sdf_chk u_chk (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .force_x   (force_x),
  .force_y   (force_y),
  .force_z   (force_z),
  .applied   (applied),
  .saturated (saturated)
);
